// ===== hdl/madt_pkg.sv =====
// Package for the MADT processor-entry parser: payload structs, constants.
// Used by every module in hdl/.
package madt_pkg;

  localparam int unsigned MaxCpus = 64;
  localparam int unsigned CntW = $clog2(MaxCpus + 1);
  localparam logic [7:0] TypeLapic = 8'd0;
  localparam logic [7:0] TypeX2apic = 8'd9;
  localparam logic [7:0] LenMin = 8'd2;
  localparam logic [7:0] LenLapic = 8'd8;
  localparam logic [7:0] LenX2apic = 8'd16;
  localparam logic [15:0] Sat16 = 16'hFFFF;
  localparam logic KindCpu = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       empty_list;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [5:0]  slot;
    logic [31:0] acpi_id;
    logic [31:0] apic_id;
    logic [31:0] cpu_flags;
    logic        is_x2apic;
    logic        parse_ok;
    logic [6:0]  cpus_kept;
    logic [15:0] total_count;
    logic [15:0] disabled_count;
    logic [15:0] overflow_count;
    logic [15:0] x2apic_count;
  } out_item_t;

  // Front-to-back event: up to one record finish plus one summary.
  typedef struct packed {
    logic        rec_done;
    logic        nine;
    logic [31:0] acpi_id;
    logic [31:0] apic_id;
    logic [31:0] flags;
    logic        clear;
    logic        summary;
    logic        fail;
  } evt_t;

endpackage

// ===== hdl/madt_front.sv =====
// Front end: walks record bytes, assembles ids and flags, flags malformed lists.
// Depends on madt_pkg.
module madt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  madt_pkg::in_item_t in_data_i,
  output logic              in_stall_o,
  output logic              evt_valid_o,
  output madt_pkg::evt_t    evt_o,
  input  logic              evt_stall_i
);

  logic [7:0]  pos_q, pos_d, typ_q, typ_d, len_q, len_d;
  logic [31:0] acpi_q, acpi_d, apic_q, apic_d, flg_q, flg_d;
  logic        fail_q, fail_d;
  logic        take;
  logic        done;
  logic [7:0]  b;

  assign in_stall_o = evt_stall_i;
  assign take = in_valid_i && !evt_stall_i;
  assign b = in_data_i.data_byte;

  always_comb begin
    logic fl;
    logic [7:0] p;
    fl = fail_q;
    p = pos_q;
    pos_d = pos_q; typ_d = typ_q; len_d = len_q;
    acpi_d = acpi_q; apic_d = apic_q; flg_d = flg_q;
    done = 1'b0;
    if (in_data_i.first_byte) begin
      fl = 1'b0;
      p = 8'd0;
    end
    fail_d = fl;
    if (!fl) begin
      if (p == 8'd0) begin
        typ_d = b; acpi_d = '0; apic_d = '0; flg_d = '0; pos_d = 8'd1;
      end else begin
        if (p == 8'd1) begin
          len_d = b;
        end else if (typ_q == madt_pkg::TypeLapic) begin
          if (p == 8'd2) acpi_d = {24'd0, b};
          else if (p == 8'd3) apic_d = {24'd0, b};
          else if (p >= 8'd4 && p <= 8'd7) flg_d[8*p[1:0] +: 8] = b;
        end else if (typ_q == madt_pkg::TypeX2apic) begin
          if (p >= 8'd4 && p <= 8'd7) apic_d[8*p[1:0] +: 8] = b;
          else if (p >= 8'd8 && p <= 8'd11) flg_d[8*p[1:0] +: 8] = b;
          else if (p >= 8'd12 && p <= 8'd15) acpi_d[8*p[1:0] +: 8] = b;
        end
        if (p == 8'd1 && (b < madt_pkg::LenMin
            || (typ_q == madt_pkg::TypeLapic && b < madt_pkg::LenLapic)
            || (typ_q == madt_pkg::TypeX2apic && b < madt_pkg::LenX2apic))) begin
          fail_d = 1'b1;
          pos_d = 8'd0;
        end else if ({1'b0, p} + 9'd1 >= {1'b0, len_d}) begin
          pos_d = 8'd0;
          done = typ_q == madt_pkg::TypeLapic || typ_q == madt_pkg::TypeX2apic;
        end else begin
          pos_d = p + 8'd1;
        end
      end
    end else begin
      pos_d = p;
    end
    if (in_data_i.last_byte) begin
      if (pos_d != 8'd0) fail_d = 1'b1;
      pos_d = 8'd0;
    end
    if (in_data_i.empty_list) begin
      pos_d = 8'd0; fail_d = 1'b0; done = 1'b0;
      typ_d = typ_q; len_d = len_q; acpi_d = acpi_q; apic_d = apic_q; flg_d = flg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; typ_q <= '0; len_q <= '0; fail_q <= 1'b0;
      acpi_q <= '0; apic_q <= '0; flg_q <= '0;
      evt_valid_o <= 1'b0;
    end else begin
      if (take) begin
        pos_q <= pos_d; typ_q <= typ_d; len_q <= len_d; fail_q <= fail_d;
        acpi_q <= acpi_d; apic_q <= apic_d; flg_q <= flg_d;
      end
      if (!evt_stall_i) begin
        evt_valid_o <= take && (done || in_data_i.last_byte || in_data_i.empty_list
                                || in_data_i.first_byte);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      evt_o.rec_done <= done;
      evt_o.nine     <= typ_q == madt_pkg::TypeX2apic;
      evt_o.acpi_id  <= acpi_d;
      evt_o.apic_id  <= apic_d;
      evt_o.flags    <= flg_d;
      evt_o.clear    <= in_data_i.first_byte || in_data_i.empty_list;
      evt_o.summary  <= in_data_i.last_byte || in_data_i.empty_list;
      evt_o.fail     <= fail_d;
    end
  end

endmodule

// ===== hdl/madt_fifo.sv =====
// Two-entry event queue between front and back ends.
// Depends on madt_pkg.
module madt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  madt_pkg::evt_t wr_data_i,
  output logic           wr_stall_o,
  output logic           rd_valid_o,
  output madt_pkg::evt_t rd_data_o,
  input  logic           rd_take_i
);

  madt_pkg::evt_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_stall_o = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_take_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== hdl/madt_back.sv =====
// Back end: keeps counters, emits CPU records and summaries through an output register.
// Depends on madt_pkg.
module madt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                evt_valid_i,
  input  madt_pkg::evt_t      evt_i,
  output logic                evt_take_o,
  output logic                out_valid_o,
  output madt_pkg::out_item_t out_data_o,
  input  logic                out_stall_i
);

  logic [madt_pkg::CntW-1:0] ret_q, ret_d;
  logic [15:0] seen_q, seen_d, dis_q, dis_d, ovf_q, ovf_d, nine_q, nine_d;
  logic        phase_q;
  logic        free, emit_rec, step;
  madt_pkg::out_item_t rec, sum;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == madt_pkg::Sat16) ? v : v + 16'd1;
  endfunction

  assign free = !out_valid_o || !out_stall_i;

  always_comb begin
    logic [madt_pkg::CntW-1:0] r;
    logic [15:0] s, d, o, n;
    logic usable;
    logic rec_in;
    logic clr;
    // In phase 1 the counters already hold this event's record; report them as they stand.
    rec_in = evt_i.rec_done && !phase_q;
    clr = evt_i.clear && !phase_q;
    r = clr ? '0 : ret_q;
    s = clr ? '0 : seen_q;
    d = clr ? '0 : dis_q;
    o = clr ? '0 : ovf_q;
    n = clr ? '0 : nine_q;
    emit_rec = 1'b0;
    usable = evt_i.flags[1:0] != 2'b00;
    if (rec_in) begin
      s = sat_inc(s);
      if (!usable) d = sat_inc(d);
      else begin
        if (evt_i.nine) n = sat_inc(n);
        if (r >= madt_pkg::CntW'(madt_pkg::MaxCpus)) o = sat_inc(o);
        else emit_rec = 1'b1;
      end
    end
    ret_d = emit_rec ? r + madt_pkg::CntW'(1) : r;
    seen_d = s; dis_d = d; ovf_d = o; nine_d = n;
    rec = '0;
    rec.result_kind = madt_pkg::KindCpu;
    rec.slot = r[5:0];
    rec.acpi_id = evt_i.acpi_id;
    rec.apic_id = evt_i.apic_id;
    rec.cpu_flags = evt_i.flags;
    rec.is_x2apic = evt_i.nine;
    sum = '0;
    sum.result_kind = madt_pkg::KindSummary;
    sum.parse_ok = !evt_i.fail;
    sum.cpus_kept = evt_i.fail ? 7'd0 : 7'(ret_d);
    sum.total_count = seen_d;
    sum.disabled_count = dis_d;
    sum.overflow_count = ovf_d;
    sum.x2apic_count = nine_d;
  end

  // Phase 1 means the CPU record of this event is out; summary still owed.
  assign step = evt_valid_i && free;
  assign evt_take_o = step && (phase_q || !(emit_rec && evt_i.summary));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ret_q <= '0; seen_q <= '0; dis_q <= '0; ovf_q <= '0; nine_q <= '0;
      phase_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      if (free) out_valid_o <= 1'b0;
      if (step) begin
        if (!phase_q) begin
          ret_q <= ret_d; seen_q <= seen_d; dis_q <= dis_d;
          ovf_q <= ovf_d; nine_q <= nine_d;
        end
        out_valid_o <= phase_q || emit_rec || evt_i.summary;
        phase_q <= !phase_q && emit_rec && evt_i.summary;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_data_o <= (phase_q || !emit_rec) ? sum : rec;
  end

endmodule

// ===== hdl/madt_cpu_entry_parser.sv =====
// MADT processor-entry parser top level: front end, event queue, back end.
// A result passes the front end's event register, the queue and the back end's output
// register; a summary following a CPU record of the same request comes after it. One
// request is taken per cycle while in_stall_o is low; a request that closes a record
// and the list at once can stall input while both results go out. Reset clears all
// counts, the record position and the queue. Depends on madt_pkg, front, fifo, back.
module madt_cpu_entry_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  madt_pkg::in_item_t  in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output madt_pkg::out_item_t out_data_o,
  input  logic                out_stall_i
);

  logic           fe_valid, fe_stall, q_valid, q_take;
  madt_pkg::evt_t fe_evt, q_evt;

  madt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid_i), .in_data_i(in_data_i), .in_stall_o(in_stall_o),
    .evt_valid_o(fe_valid), .evt_o(fe_evt), .evt_stall_i(fe_stall)
  );

  madt_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fe_valid), .wr_data_i(fe_evt), .wr_stall_o(fe_stall),
    .rd_valid_o(q_valid), .rd_data_o(q_evt), .rd_take_i(q_take)
  );

  madt_back u_back (
    .clk_i, .rst_ni,
    .evt_valid_i(q_valid), .evt_i(q_evt), .evt_take_o(q_take),
    .out_valid_o(out_valid_o), .out_data_o(out_data_o), .out_stall_i(out_stall_i)
  );

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o)) else $error("held");
  a_sum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == madt_pkg::KindSummary && !out_data_o.parse_ok
    |-> out_data_o.cpus_kept == 7'd0) else $error("cpus_kept");
  a_rec_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == madt_pkg::KindCpu |-> !out_data_o.parse_ok)
    else $error("rec");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for madt_cpu_entry_parser: drives entry-list bytes, predicts records and summaries.
// Depends on madt_pkg and the parser RTL in hdl/.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  madt_pkg::in_item_t in_data = '0;
  logic in_stall;
  logic out_valid;
  madt_pkg::out_item_t out_data;
  logic out_stall = 1'b0;

  madt_cpu_entry_parser dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid), .in_data_i(in_data),
    .in_stall_o(in_stall), .out_valid_o(out_valid), .out_data_o(out_data),
    .out_stall_i(out_stall)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0] pos_q = '0, rtype_q = '0, rlen_q = '0;
  logic [31:0] acpi_q = '0, apic_q = '0, flags_q = '0;
  int unsigned kept_q = 0;
  logic [15:0] seen_q = '0, disabled_q = '0, overflow_q = '0, nine_q = '0;
  logic bad_q = 1'b0;
  madt_pkg::out_item_t expected_q[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned sent = 0;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == madt_pkg::Sat16) ? v : v + 16'd1;
  endfunction

  function automatic void clear_counts();
    pos_q = '0; kept_q = 0; seen_q = '0; disabled_q = '0;
    overflow_q = '0; nine_q = '0; bad_q = 1'b0;
  endfunction

  function automatic void push_summary();
    madt_pkg::out_item_t s;
    s = '0;
    s.result_kind = madt_pkg::KindSummary;
    s.parse_ok = !bad_q;
    s.cpus_kept = bad_q ? 7'd0 : 7'(kept_q);
    s.total_count = seen_q;
    s.disabled_count = disabled_q;
    s.overflow_count = overflow_q;
    s.x2apic_count = nine_q;
    expected_q.push_back(s);
  endfunction

  function automatic void close_cpu();
    madt_pkg::out_item_t r;
    logic nine;
    nine = (rtype_q == madt_pkg::TypeX2apic);
    seen_q = sat_inc(seen_q);
    if (flags_q[1:0] == 2'b00) begin
      disabled_q = sat_inc(disabled_q);
      return;
    end
    if (nine) nine_q = sat_inc(nine_q);
    if (kept_q >= madt_pkg::MaxCpus) begin
      overflow_q = sat_inc(overflow_q);
      return;
    end
    r = '0;
    r.result_kind = madt_pkg::KindCpu;
    r.slot = 6'(kept_q);
    r.acpi_id = acpi_q;
    r.apic_id = apic_q;
    r.cpu_flags = flags_q;
    r.is_x2apic = nine;
    expected_q.push_back(r);
    kept_q++;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int unsigned p;
    p = pos_q;
    if (bad_q) return;
    if (p == 0) begin
      rtype_q = b; acpi_q = '0; apic_q = '0; flags_q = '0; pos_q = 8'd1;
      return;
    end
    if (p == 1) begin
      rlen_q = b;
      if (b < madt_pkg::LenMin || (rtype_q == madt_pkg::TypeLapic && b < madt_pkg::LenLapic) ||
          (rtype_q == madt_pkg::TypeX2apic && b < madt_pkg::LenX2apic)) begin
        bad_q = 1'b1; pos_q = '0;
        return;
      end
    end else if (rtype_q == madt_pkg::TypeLapic) begin
      if (p == 2) acpi_q = {24'd0, b};
      else if (p == 3) apic_q = {24'd0, b};
      else if (p >= 4 && p <= 7) flags_q[8*(p-4) +: 8] = b;
    end else if (rtype_q == madt_pkg::TypeX2apic) begin
      if (p >= 4 && p <= 7) apic_q[8*(p-4) +: 8] = b;
      else if (p >= 8 && p <= 11) flags_q[8*(p-8) +: 8] = b;
      else if (p >= 12 && p <= 15) acpi_q[8*(p-12) +: 8] = b;
    end
    if (p + 1 >= rlen_q) begin
      pos_q = '0;
      if (rtype_q == madt_pkg::TypeLapic || rtype_q == madt_pkg::TypeX2apic) close_cpu();
      return;
    end
    pos_q = 8'(p + 1);
  endfunction

  function automatic void predict(madt_pkg::in_item_t it);
    if (it.empty_list) begin
      clear_counts();
      push_summary();
      return;
    end
    if (it.first_byte) clear_counts();
    take_byte(it.data_byte);
    if (it.last_byte) begin
      if (pos_q != 0) bad_q = 1'b1;
      pos_q = '0;
      push_summary();
    end
  endfunction

  task automatic report_mismatch(string what, madt_pkg::out_item_t got,
                                 madt_pkg::out_item_t want);
    $display("MISMATCH %s at cycle %0d: got %h want %h", what, cycles, got, want);
    errors++;
  endtask

  // send one request; hold until accepted
  task automatic send_byte(logic [7:0] b, bit first, bit last, bit empty);
    while (sender_idle != 0 && $urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, first_byte: first, last_byte: last, empty_list: empty};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict('{data_byte: b, first_byte: first, last_byte: last, empty_list: empty});
    sent++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_ni) out_stall <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk_i) begin
    madt_pkg::out_item_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data, '0);
      end else begin
        e = expected_q.pop_front();
        if (out_data !== e) report_mismatch("result", out_data, e);
      end
    end
  end

  // drop valid, then hold until every expected result has come
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // one record of len bytes; flags from the caller at the type's offsets, other bytes random
  task automatic send_record(logic [7:0] rtype, logic [7:0] len, logic [31:0] flags,
                             bit first, bit last);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if (i == 0) b = rtype;
      else if (i == 1) b = len;
      else if (rtype == madt_pkg::TypeLapic && i >= 4 && i <= 7) b = flags[8*(i-4) +: 8];
      else if (rtype == madt_pkg::TypeX2apic && i >= 8 && i <= 11) b = flags[8*(i-8) +: 8];
      else b = 8'($urandom);
      send_byte(b, first && i == 0, last && i == len - 1, 1'b0);
    end
  endtask

  function automatic logic [31:0] rand_flags();
    logic [31:0] f;
    f = $urandom;
    if ($urandom_range(3) == 0) f[1:0] = 2'b00;
    return f;
  endfunction

  task automatic send_list(int unsigned nrec, bit corrupt);
    logic [7:0] t, len;
    int unsigned k;
    if (nrec == 0) begin
      send_byte(8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      return;
    end
    for (k = 0; k < nrec; k++) begin
      case ($urandom_range(9)) inside
        [0:3]: begin
          t = madt_pkg::TypeLapic;
          len = 8'(madt_pkg::LenLapic + $urandom_range(2));
        end
        [4:7]: begin
          t = madt_pkg::TypeX2apic;
          len = 8'(madt_pkg::LenX2apic + $urandom_range(2));
        end
        default: begin t = 8'($urandom_range(1, 255)); len = 8'($urandom_range(2, 6)); end
      endcase
      if (t == madt_pkg::TypeX2apic && len < madt_pkg::LenX2apic) len = madt_pkg::LenX2apic;
      if (corrupt && k == nrec - 1) begin
        if ($urandom_range(1)) begin
          // short length
          send_byte(t, k == 0, 1'b0, 1'b0);
          send_byte(8'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0);
          send_byte(8'($urandom), 1'b0, 1'b1, 1'b0);
        end else begin
          // truncated record
          for (int i = 0; i < 3; i++)
            send_byte(i == 0 ? t : (i == 1 ? len : 8'($urandom)), k == 0, i == 2, 1'b0);
        end
      end else begin
        send_record(t, len, rand_flags(), k == 0, k == nrec - 1);
      end
    end
  endtask

  task automatic test_directed();
    send_byte(8'hFF, 1'b1, 1'b1, 1'b1);                 // empty list
    send_record(madt_pkg::TypeLapic, madt_pkg::LenLapic, 32'h1, 1'b1, 1'b1);
    send_record(madt_pkg::TypeX2apic, madt_pkg::LenX2apic, 32'hFFFF_FFFE, 1'b1, 1'b0);
    send_record(madt_pkg::TypeLapic, madt_pkg::LenLapic, 32'h0, 1'b0, 1'b1); // disabled
    send_byte(madt_pkg::TypeLapic, 1'b1, 1'b1, 1'b0);   // lone type byte
    send_byte(madt_pkg::TypeX2apic, 1'b1, 1'b0, 1'b0);  // short x2apic length
    send_byte(8'd15, 1'b0, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1, 1'b0);
    send_byte(madt_pkg::TypeLapic, 1'b1, 1'b0, 1'b0);   // first mark mid-record
    send_byte(8'd5, 1'b1, 1'b0, 1'b0);
    send_byte(8'd1, 1'b0, 1'b0, 1'b0);                  // length below two
    send_byte(8'h00, 1'b0, 1'b1, 1'b0);
    wait_drain();
  endtask

  // fill past all slots, then accumulate without a first mark
  task automatic test_overflow();
    for (int i = 0; i < madt_pkg::MaxCpus + 3; i++)
      send_record(madt_pkg::TypeLapic, madt_pkg::LenLapic, 32'h2, i == 0,
                  i == madt_pkg::MaxCpus + 2);
    send_record(madt_pkg::TypeX2apic, madt_pkg::LenX2apic, 32'h3, 1'b0, 1'b1);
    wait_drain();
  endtask

  task automatic test_random(int unsigned items, int unsigned idle, int unsigned stall);
    int unsigned stop;
    sender_idle = idle;
    recv_stall = stall;
    stop = sent + items;
    while (sent < stop) send_list($urandom_range(0, 5), $urandom_range(4) == 0);
    wait_drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(100, 0, 0);
    test_random(100, 67, 0);
    test_random(100, 0, 67);
    test_random(100, 35, 35);
    sender_idle = 0;
    recv_stall = 0;
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/madt_pkg.sv
hdl/madt_front.sv
hdl/madt_fifo.sv
hdl/madt_back.sv
hdl/madt_cpu_entry_parser.sv
sim/tb_top.sv
